// ===== design/pileup_region_caller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Pileup region caller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PILEUP_REGION_CALLER_TOP_DEFINES_SVH
`define PILEUP_REGION_CALLER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pileup region caller package
// Widths, reset values, register indexes, controller states and the command
// and status bundles shared by the modules of the region caller.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int POS_BITS_DEF = 32;
  localparam int TOT_BITS_DEF = 48;

  localparam int COV_W  = 15;
  localparam int GAP_W  = 17;
  localparam int HITS_W = 15;
  localparam int MGAP_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;
  localparam int OUT_POS_W  = 32;
  localparam int OUT_TOT_W  = 48;
  localparam int TENTHS_W   = 19;
  localparam int FRAC_W     = 4;

  localparam logic [COV_W-1:0]    COV_MAX        = 15'h7fff;
  localparam logic [GAP_W-1:0]    GAP_MAX        = 17'h1ffff;
  localparam logic [HITS_W-1:0]   MIN_HITS_RST   = 15'd50;
  localparam logic [MGAP_W-1:0]   MAX_GAP_RST    = 16'd20;
  localparam logic [TENTHS_W-1:0] TENTHS_SAT     = 19'd327670;

  localparam logic [IDX_W-1:0] REG_MIN_HITS = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_GAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUO,
    ST_FLOAD,
    ST_FRAC,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic quo_step;
    logic frac_init;
    logic frac_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic quo_last;
    logic frac_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/prc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pileup region caller controller
// Sequences item intake, the two division passes and the result hand-off.
// ----------------------------------------------------------------------------
module prc_ctrl
  import prc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.emit) state_nxt = ST_QUO;
      end
      ST_QUO: begin
        if (sts.quo_last) state_nxt = ST_FLOAD;
      end
      ST_FLOAD: begin
        state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        if (sts.frac_last) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.load = in_valid && sts.emit;
      end
      ST_QUO: begin
        cmd.quo_step = 1'b1;
      end
      ST_FLOAD: begin
        cmd.frac_init = 1'b1;
      end
      ST_FRAC: begin
        cmd.frac_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/prc_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pileup region caller region tracker
// Holds the configuration, the base position and the open region, and
// presents the region fields to be emitted with the current base.
// ----------------------------------------------------------------------------
module prc_track
  import prc_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF,
  parameter int TOTAL_BITS    = TOT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [COV_W-1:0]         in_coverage,
  input  logic                     in_last_base,
  input  cmd_t                     cmd,
  output logic                     emit,
  output logic [POSITION_BITS-1:0] emit_start,
  output logic [POSITION_BITS-1:0] emit_end,
  output logic [COV_W-1:0]         emit_min,
  output logic [COV_W-1:0]         emit_max,
  output logic [TOTAL_BITS-1:0]    emit_total
);

  logic [HITS_W-1:0]        min_hits_r;
  logic [MGAP_W-1:0]        max_gap_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     in_region_r;
  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] end_r;
  logic [COV_W-1:0]         min_r;
  logic [COV_W-1:0]         max_r;
  logic [TOTAL_BITS-1:0]    total_r;
  logic [GAP_W-1:0]         gap_r;

  logic                     covered;
  logic                     gap_close;
  logic                     clear;
  logic [GAP_W-1:0]         gap_inc;
  logic [TOTAL_BITS:0]      sum;
  logic [POSITION_BITS-1:0] pos_inc;

  logic                     in_region_nxt;
  logic [POSITION_BITS-1:0] start_nxt;
  logic [POSITION_BITS-1:0] end_nxt;
  logic [COV_W-1:0]         min_nxt;
  logic [COV_W-1:0]         max_nxt;
  logic [TOTAL_BITS-1:0]    total_nxt;
  logic [GAP_W-1:0]         gap_nxt;

  assign pos_inc = pos_r + POSITION_BITS'(1);
  assign covered = in_coverage >= min_hits_r;
  assign gap_inc = (gap_r < GAP_MAX) ? gap_r + GAP_W'(1) : gap_r;
  assign sum     = {1'b0, total_r} + (TOTAL_BITS+1)'(in_coverage);

  always_comb begin
    in_region_nxt = in_region_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    total_nxt     = total_r;
    gap_nxt       = gap_r;
    gap_close     = 1'b0;
    if (covered) begin
      if (!in_region_r) start_nxt = pos_r;
      end_nxt       = pos_inc;
      if (in_coverage < min_r) min_nxt = in_coverage;
      if (in_coverage > max_r) max_nxt = in_coverage;
      total_nxt     = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
      in_region_nxt = 1'b1;
      gap_nxt       = '0;
    end else if (in_region_r) begin
      gap_nxt   = gap_inc;
      gap_close = gap_inc > {1'b0, max_gap_r};
    end
  end

  // The emitted fields are the region after this base, before any clearing.
  assign emit       = gap_close || (in_last_base && in_region_nxt);
  assign clear      = gap_close || in_last_base;
  assign emit_start = start_nxt;
  assign emit_end   = end_nxt;
  assign emit_min   = min_nxt;
  assign emit_max   = max_nxt;
  assign emit_total = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hits_r <= MIN_HITS_RST;
      max_gap_r  <= MAX_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_HITS: min_hits_r <= cfg_wdata[HITS_W-1:0];
        REG_MAX_GAP:  max_gap_r  <= cfg_wdata[MGAP_W-1:0];
        default: begin
          min_hits_r <= min_hits_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      in_region_r <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      min_r       <= COV_MAX;
      max_r       <= '0;
      total_r     <= '0;
      gap_r       <= '0;
    end else if (cmd.take) begin
      pos_r <= in_last_base ? '0 : pos_inc;
      if (clear) begin
        in_region_r <= 1'b0;
        start_r     <= '0;
        end_r       <= '0;
        min_r       <= COV_MAX;
        max_r       <= '0;
        total_r     <= '0;
        gap_r       <= '0;
      end else begin
        in_region_r <= in_region_nxt;
        start_r     <= start_nxt;
        end_r       <= end_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        total_r     <= total_nxt;
        gap_r       <= gap_nxt;
      end
    end
  end

endmodule

// ===== design/prc_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pileup region caller mean unit
// Captures an emitted region, divides its total by its span one quotient bit
// per cycle, rounds the tenths digit and holds the result beat.
// ----------------------------------------------------------------------------
module prc_mean
  import prc_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF,
  parameter int TOTAL_BITS    = TOT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [POSITION_BITS-1:0] emit_start,
  input  logic [POSITION_BITS-1:0] emit_end,
  input  logic [COV_W-1:0]         emit_min,
  input  logic [COV_W-1:0]         emit_max,
  input  logic [TOTAL_BITS-1:0]    emit_total,
  output logic                     quo_last,
  output logic                     frac_last,
  output logic                     out_free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_POS_W-1:0]     out_region_start,
  output logic [OUT_POS_W-1:0]     out_region_end,
  output logic [COV_W-1:0]         out_mean_floor,
  output logic [TENTHS_W-1:0]      out_mean_tenths,
  output logic [COV_W-1:0]         out_min_coverage,
  output logic [COV_W-1:0]         out_max_coverage,
  output logic [OUT_TOT_W-1:0]     out_total_coverage
);

  localparam int CNT_W  = $clog2(TOTAL_BITS);
  localparam int SPAN_W = POSITION_BITS + 1;
  localparam int V_W    = POSITION_BITS + 5;

  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] end_r;
  logic [COV_W-1:0]         min_r;
  logic [COV_W-1:0]         max_r;
  logic [TOTAL_BITS-1:0]    tot_r;
  logic [TOTAL_BITS-1:0]    dvd_r;
  logic [SPAN_W-1:0]        rem_r;
  logic [FRAC_W-1:0]        frac_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;

  logic [POSITION_BITS-1:0] span_lo;
  logic [SPAN_W-1:0]        span;
  logic                     next_bit;
  logic [SPAN_W:0]          shifted;
  logic [SPAN_W:0]          diff;
  logic                     qbit;
  logic [SPAN_W-1:0]        rem_step;
  logic [V_W-1:0]           frac_num;
  logic [COV_W-1:0]         q15;
  logic                     sat;
  logic [TENTHS_W-1:0]      tenths;

  // A span of zero modulo the position range stands for the full range.
  assign span_lo = end_r - start_r;
  assign span    = {span_lo == '0, span_lo};

  // One restoring division step, shared by the quotient and tenths passes.
  assign next_bit = cmd.frac_step ? frac_r[FRAC_W-1] : dvd_r[TOTAL_BITS-1];
  assign shifted  = {rem_r, next_bit};
  assign diff     = shifted - {1'b0, span};
  assign qbit     = shifted >= {1'b0, span};
  assign rem_step = qbit ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];

  // Ten times the remainder plus half the span; its quotient is at most ten.
  assign frac_num = V_W'({rem_r, 3'b000}) + V_W'({rem_r, 1'b0}) + V_W'(span >> 1);

  assign q15    = dvd_r[COV_W-1:0];
  assign sat    = (|dvd_r[TOTAL_BITS-1:COV_W]) || (q15 == COV_MAX);
  assign tenths = TENTHS_W'({q15, 3'b000}) + TENTHS_W'({q15, 1'b0}) + TENTHS_W'(frac_r);

  assign quo_last  = cnt_r == CNT_W'(TOTAL_BITS - 1);
  assign frac_last = cnt_r == CNT_W'(FRAC_W - 1);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= emit_start;
      end_r   <= emit_end;
      min_r   <= emit_min;
      max_r   <= emit_max;
      tot_r   <= emit_total;
      dvd_r   <= emit_total;
      rem_r   <= '0;
    end else if (cmd.quo_step) begin
      dvd_r <= {dvd_r[TOTAL_BITS-2:0], qbit};
      rem_r <= rem_step;
    end else if (cmd.frac_init) begin
      rem_r  <= frac_num[V_W-1:FRAC_W];
      frac_r <= frac_num[FRAC_W-1:0];
    end else if (cmd.frac_step) begin
      frac_r <= {frac_r[FRAC_W-2:0], qbit};
      rem_r  <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load || cmd.frac_init) begin
      cnt_r <= '0;
    end else if (cmd.quo_step || cmd.frac_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_region_start   <= OUT_POS_W'(start_r);
      out_region_end     <= OUT_POS_W'(end_r);
      out_mean_floor     <= sat ? COV_MAX : q15;
      out_mean_tenths    <= sat ? TENTHS_SAT : tenths;
      out_min_coverage   <= min_r;
      out_max_coverage   <= max_r;
      out_total_coverage <= OUT_TOT_W'(tot_r);
    end
  end

endmodule

// ===== design/pileup_region_caller_top.sv =====
`timescale 1ns / 1ps
// Rate: bases that close no region are taken at one base per cycle.
// A base that closes a region makes the block busy until its result is loaded,
// through the one-bit-per-cycle divider: TOTAL_BITS quotient steps, one setup,
// four tenths steps and one load of the output register (plus any stall there).
// Reset is synchronous and active low: it clears the region, the base position
// and the output beat, and sets min_hits to 50 and max_gap to 20.
// ----------------------------------------------------------------------------
// Pileup region caller top level
// Calls high-coverage regions in a per-base coverage stream and reports each
// region's extent, floor mean, mean in tenths, minimum, maximum and total.
// ----------------------------------------------------------------------------
`include "pileup_region_caller_top_defines.svh"

module pileup_region_caller_top
  import prc_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF,
  parameter int TOTAL_BITS    = TOT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COV_W-1:0]     in_coverage,
  input  logic                 in_last_base,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_POS_W-1:0] out_region_start,
  output logic [OUT_POS_W-1:0] out_region_end,
  output logic [COV_W-1:0]     out_mean_floor,
  output logic [TENTHS_W-1:0]  out_mean_tenths,
  output logic [COV_W-1:0]     out_min_coverage,
  output logic [COV_W-1:0]     out_max_coverage,
  output logic [OUT_TOT_W-1:0] out_total_coverage
);

  // The controller only drives in_ready and the command bits; the tracker and the mean unit
  // report back through the status bundle.
  cmd_t cmd;
  sts_t sts;

  // Region fields as they stand after the current base, captured by the
  // mean unit on the beat that closes a region.
  logic [POSITION_BITS-1:0] emit_start;
  logic [POSITION_BITS-1:0] emit_end;
  logic [COV_W-1:0]         emit_min;
  logic [COV_W-1:0]         emit_max;
  logic [TOTAL_BITS-1:0]    emit_total;

  prc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prc_track #(
    .POSITION_BITS (POSITION_BITS),
    .TOTAL_BITS    (TOTAL_BITS)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_coverage  (in_coverage),
    .in_last_base (in_last_base),
    .cmd          (cmd),
    .emit         (sts.emit),
    .emit_start   (emit_start),
    .emit_end     (emit_end),
    .emit_min     (emit_min),
    .emit_max     (emit_max),
    .emit_total   (emit_total)
  );

  // The output register lets the next bases stream in while a result beat
  // waits; only a second closing region waits for the first to be taken.
  prc_mean #(
    .POSITION_BITS (POSITION_BITS),
    .TOTAL_BITS    (TOTAL_BITS)
  ) u_mean (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .emit_start         (emit_start),
    .emit_end           (emit_end),
    .emit_min           (emit_min),
    .emit_max           (emit_max),
    .emit_total         (emit_total),
    .quo_last           (sts.quo_last),
    .frac_last          (sts.frac_last),
    .out_free           (sts.out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_region_start   (out_region_start),
    .out_region_end     (out_region_end),
    .out_mean_floor     (out_mean_floor),
    .out_mean_tenths    (out_mean_tenths),
    .out_min_coverage   (out_min_coverage),
    .out_max_coverage   (out_max_coverage),
    .out_total_coverage (out_total_coverage)
  );

  // A closing beat starts the divider, so intake must stop at once.
  `PRC_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready, "intake open during division")

  // Division steps never overlap with intake.
  `PRC_ASSERT_SAME(a_no_step_idle, in_ready, !(cmd.quo_step || cmd.frac_step || cmd.frac_init),
    "divider stepping while idle")

  // Loading the result register always presents a beat.
  `PRC_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "result load without valid beat")

  // The tenths figure lies within one unit of ten times the floor mean.
  `PRC_ASSERT_SAME(a_tenths_range, out_valid,
    (out_mean_tenths >= 19'(out_mean_floor) * 19'd10) &&
    (out_mean_tenths <= 19'(out_mean_floor) * 19'd10 + 19'd10),
    "mean tenths inconsistent with floor mean")

endmodule
